@@ rtl/core/srsw_pkg.sv @@
// shared types and constants for the selective-repeat sender window
// no dependencies
`timescale 1ns / 1ps

package srsw_pkg;

   localparam int ELAPSED_W = 16;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
   localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
   localparam logic [2:0] MAX_RETX = 3'd4;

   // event kinds on the request side
   localparam logic [1:0] FUNC_NEW  = 2'd0;
   localparam logic [1:0] FUNC_ACK  = 2'd1;
   localparam logic [1:0] FUNC_TICK = 2'd2;

   // response actions
   localparam logic [1:0] ACT_NONE   = 2'd0;
   localparam logic [1:0] ACT_SEND   = 2'd1;
   localparam logic [1:0] ACT_RETX   = 2'd2;
   localparam logic [1:0] ACT_REJECT = 2'd3;

   typedef struct packed {
      logic                 acked;
      logic [ELAPSED_W-1:0] elapsed;
   } slot_type;

   typedef struct packed {
      logic load;   // take neighbor data
      logic clear;  // fresh slot for a new packet
      logic mark;   // acknowledged
   } cell_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SLIDE  = 4'b0010,
      ST_SWEEP  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

endpackage

@@ rtl/core/selective_repeat_sender_window.sv @@
// selective-repeat sender window, a row of WINDOW slot cells shifting toward slot 0
// new packet or unused event: finish state, then response register; ack: slide out acked head
// slots; tick: rotate the row once past the head, stalling when a retransmit meets a full
// response register; one event at a time, ready again once the last response is loaded
// reset: synchronous, clears base, next and all cells, timeout back to 2000, no clearing pass
// depends on srsw_pkg and srsw_cell
`timescale 1ns / 1ps

module selective_repeat_sender_window
   import srsw_pkg::*;
#(
   parameter int WINDOW   = 4,
   parameter int SEQ_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_ack_seq,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_action,
   output logic [15:0] rsp_seq,
   output logic [2:0]  rsp_in_flight,
   output logic        rsp_all_acked,
   output logic        rsp_last,
   input  logic        csr_write_en,
   input  logic [15:0] csr_write_data
);

   localparam int CW = (SEQ_BITS > 6) ? SEQ_BITS : 6;
   localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [CW-1:0] WINDOW_C = CW'(WINDOW);
   localparam logic [IW-1:0] LAST_STEP = IW'(WINDOW - 1);

   state_type             state_ff, state_in;
   logic [15:0]           timeout_ff, timeout_in;
   logic [SEQ_BITS-1:0]   base_ff, base_in;
   logic [SEQ_BITS-1:0]   next_ff, next_in;
   logic [SEQ_BITS-1:0]   sweep_seq_ff, sweep_seq_in;
   logic [IW-1:0]         step_ff, step_in;
   logic [2:0]            cnt_ff, cnt_in;
   logic [1:0]            pend_action_ff, pend_action_in;
   logic [15:0]           pend_seq_ff, pend_seq_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_action_ff, rsp_action_in;
   logic [15:0]           rsp_seq_ff, rsp_seq_in;
   logic [2:0]            rsp_in_flight_ff, rsp_in_flight_in;
   logic                  rsp_all_acked_ff, rsp_all_acked_in;
   logic                  rsp_last_ff, rsp_last_in;

   slot_type              cell_q [WINDOW];
   slot_type              tail_in;
   slot_type              head_new;

   logic [SEQ_BITS-1:0]   n_seq;
   logic [CW-1:0]         n_ext;
   logic [SEQ_BITS+15:0]  ack_wide;
   logic [SEQ_BITS-1:0]   ack_s;
   logic [SEQ_BITS-1:0]   off_seq;
   logic [CW-1:0]         off_ext;
   logic [SEQ_BITS+15:0]  sweep_seq_wide;
   logic                  accept;
   logic                  out_free;
   logic                  win_full;
   logic                  new_ok;
   logic                  ack_ok;
   logic                  shift_all;
   logic                  in_win;
   logic                  active;
   logic [ELAPSED_W-1:0]  e_inc;
   logic                  fire;
   logic                  stall;
   logic                  push;
   logic                  push_last;

   assign n_seq    = next_ff - base_ff;
   assign n_ext    = CW'(n_seq);
   assign ack_wide = {{SEQ_BITS{1'b0}}, req_ack_seq};
   assign ack_s    = ack_wide[SEQ_BITS-1:0];
   assign off_seq  = ack_s - base_ff;
   assign off_ext  = CW'(off_seq);
   assign sweep_seq_wide = {16'b0, sweep_seq_ff};

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign win_full  = (n_ext >= WINDOW_C) || (n_seq == '1);
   assign new_ok    = accept && (req_func == FUNC_NEW) && !win_full;
   assign ack_ok    = accept && (req_func == FUNC_ACK) && (off_ext < n_ext);

   // head of the row, worked on during a tick sweep
   assign in_win = (CW'(step_ff) < n_ext);
   assign active = in_win && !cell_q[0].acked;
   assign e_inc  = (cell_q[0].elapsed == ELAPSED_MAX) ? cell_q[0].elapsed
                                                      : cell_q[0].elapsed + 1'b1;
   assign fire   = active && (e_inc > timeout_ff) && (cnt_ff < MAX_RETX);
   assign stall  = fire && (cnt_ff != 3'd0) && !out_free;

   always_comb begin
      head_new = cell_q[0];
      if (fire) begin
         head_new.elapsed = '0;
      end else if (active) begin
         head_new.elapsed = e_inc;
      end
   end

   assign shift_all = ((state_ff == ST_SLIDE) && (n_seq != '0) && cell_q[0].acked)
                   || ((state_ff == ST_SWEEP) && !stall);
   assign tail_in   = (state_ff == ST_SWEEP) ? head_new : '0;

   genvar gi;
   generate
      for (gi = 0; gi < WINDOW; gi++) begin : g_cell
         cell_ctl_type ctl;
         slot_type     d_in;
         assign ctl.load  = shift_all;
         assign ctl.clear = new_ok && (n_ext == CW'(gi));
         assign ctl.mark  = ack_ok && (off_ext == CW'(gi));
         if (gi == WINDOW - 1) begin : g_tail
            assign d_in = tail_in;
         end else begin : g_mid
            assign d_in = cell_q[gi+1];
         end
         srsw_cell u_cell (
            .clock (clock),
            .reset (reset),
            .ctl   (ctl),
            .d_in  (d_in),
            .q     (cell_q[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in       = state_ff;
      timeout_in     = csr_write_en ? csr_write_data : timeout_ff;
      base_in        = base_ff;
      next_in        = next_ff;
      sweep_seq_in   = sweep_seq_ff;
      step_in        = step_ff;
      cnt_in         = cnt_ff;
      pend_action_in = pend_action_ff;
      pend_seq_in    = pend_seq_ff;
      push           = 1'b0;
      push_last      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_action_in = ACT_NONE;
               pend_seq_in    = '0;
               state_in       = ST_FINISH;
               case (req_func)
                  FUNC_NEW: begin
                     if (win_full) begin
                        pend_action_in = ACT_REJECT;
                     end else begin
                        pend_action_in = ACT_SEND;
                        pend_seq_in    = 16'(({16'b0, next_ff}));
                        next_in        = next_ff + SEQ_BITS'(1);
                     end
                  end
                  FUNC_ACK: begin
                     state_in = ST_SLIDE;
                  end
                  FUNC_TICK: begin
                     state_in     = ST_SWEEP;
                     step_in      = '0;
                     cnt_in       = '0;
                     sweep_seq_in = base_ff;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_SLIDE: begin
            if (shift_all) begin
               base_in = base_ff + SEQ_BITS'(1);
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SWEEP: begin
            if (!stall) begin
               if (fire) begin
                  // the previous retransmit is known not to be the final one
                  push           = (cnt_ff != 3'd0);
                  pend_action_in = ACT_RETX;
                  pend_seq_in    = sweep_seq_wide[15:0];
                  cnt_in         = cnt_ff + 3'd1;
               end
               step_in      = step_ff + IW'(1);
               sweep_seq_in = sweep_seq_ff + SEQ_BITS'(1);
               if (step_ff == LAST_STEP) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               push      = 1'b1;
               push_last = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_action_in    = rsp_action_ff;
      rsp_seq_in       = rsp_seq_ff;
      rsp_in_flight_in = rsp_in_flight_ff;
      rsp_all_acked_in = rsp_all_acked_ff;
      rsp_last_in      = rsp_last_ff;
      if (push) begin
         rsp_valid_in     = 1'b1;
         rsp_action_in    = pend_action_ff;
         rsp_seq_in       = pend_seq_ff;
         rsp_in_flight_in = n_seq[2:0];
         rsp_all_acked_in = (n_seq == '0);
         rsp_last_in      = push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         timeout_ff   <= TIMEOUT_RESET;
         base_ff      <= '0;
         next_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         timeout_ff   <= timeout_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sweep_seq_ff     <= sweep_seq_in;
      step_ff          <= step_in;
      pend_action_ff   <= pend_action_in;
      pend_seq_ff      <= pend_seq_in;
      rsp_action_ff    <= rsp_action_in;
      rsp_seq_ff       <= rsp_seq_in;
      rsp_in_flight_ff <= rsp_in_flight_in;
      rsp_all_acked_ff <= rsp_all_acked_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_action    = rsp_action_ff;
   assign rsp_seq       = rsp_seq_ff;
   assign rsp_in_flight = rsp_in_flight_ff;
   assign rsp_all_acked = rsp_all_acked_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTHESIS
   a_window_bound: assert property (@(posedge clock) disable iff (reset)
      n_ext <= WINDOW_C)
      else $error("outstanding count beyond window");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted transfer not processed");

   a_retx_limit: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAX_RETX)
      else $error("too many retransmits in one tick");

   a_send_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_action == ACT_SEND)) |-> rsp_last)
      else $error("send command not final response");

   a_no_push_overwrite: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("response register overwritten");
`endif

endmodule

@@ rtl/core/srsw_cell.sv @@
// one window slot: acknowledge flag and saturating retransmit timer
// depends on srsw_pkg
`timescale 1ns / 1ps

module srsw_cell
   import srsw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  slot_type     d_in,
   output slot_type     q
);

   slot_type slot_ff;
   slot_type slot_in;

   always_comb begin
      slot_in = slot_ff;
      if (ctl.clear) begin
         slot_in = '0;
      end else if (ctl.load) begin
         slot_in = d_in;
      end else if (ctl.mark) begin
         slot_in.acked = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign q = slot_ff;

endmodule

@@ tb/srsw_window_checker.sv @@
// checker for the selective-repeat sender window: follows every transfer, keeps its own
// copy of the window state, predicts the responses and compares them in order
// depends on srsw_pkg
`timescale 1ns / 1ps

module srsw_window_checker
   import srsw_pkg::*;
#(
   parameter int WINDOW = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_ack_seq,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_action,
   input  logic [15:0] rsp_seq,
   input  logic [2:0]  rsp_in_flight,
   input  logic        rsp_all_acked,
   input  logic        rsp_last,
   input  logic        csr_write_en,
   input  logic [15:0] csr_write_data,
   output int          fail_count,
   output int          pending_results,
   output int          checked_count,
   output logic [15:0] window_base,
   output logic [15:0] window_next
);

   localparam int RETX_MAX = int'(MAX_RETX);

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] seq;
      logic [2:0]  in_flight;
      logic        all_acked;
      logic        last;
   } response_type;

   logic [15:0]          timeout_ticks;
   logic                 slot_acked [WINDOW];
   logic [ELAPSED_W-1:0] slot_elapsed [WINDOW];
   response_type         response_q [$];
   response_type         want;

   task automatic apply_event(input logic [1:0] func, input logic [15:0] ack);
      logic [1:0]   acts [RETX_MAX];
      logic [15:0]  seqs [RETX_MAX];
      logic [15:0]  span;
      logic [15:0]  off;
      int           n;
      int           i;
      response_type r;
      n = 0;
      span = window_next - window_base;
      case (func)
         FUNC_NEW: begin
            if (span < WINDOW) begin
               slot_acked[span] = 1'b0;
               slot_elapsed[span] = '0;
               acts[n] = ACT_SEND;
               seqs[n] = window_next;
               n++;
               window_next = window_next + 16'd1;
            end else begin
               acts[n] = ACT_REJECT;
               seqs[n] = '0;
               n++;
            end
         end
         FUNC_ACK: begin
            off = ack - window_base;
            if (off < span && off < WINDOW) begin
               slot_acked[off] = 1'b1;
               // slide past every acknowledged slot at the front
               while (window_next != window_base && slot_acked[0]) begin
                  for (i = 0; i < WINDOW - 1; i++) begin
                     slot_acked[i] = slot_acked[i + 1];
                     slot_elapsed[i] = slot_elapsed[i + 1];
                  end
                  slot_acked[WINDOW - 1] = 1'b0;
                  slot_elapsed[WINDOW - 1] = '0;
                  window_base = window_base + 16'd1;
               end
            end
            acts[n] = ACT_NONE;
            seqs[n] = '0;
            n++;
         end
         FUNC_TICK: begin
            for (i = 0; i < WINDOW && i < span; i++) begin
               if (!slot_acked[i]) begin
                  if (slot_elapsed[i] != ELAPSED_MAX) begin
                     slot_elapsed[i] = slot_elapsed[i] + 1'b1;
                  end
                  // expired slots beyond the report limit keep their timers
                  if (slot_elapsed[i] > timeout_ticks && n < RETX_MAX) begin
                     slot_elapsed[i] = '0;
                     acts[n] = ACT_RETX;
                     seqs[n] = window_base + 16'(i);
                     n++;
                  end
               end
            end
            if (n == 0) begin
               acts[n] = ACT_NONE;
               seqs[n] = '0;
               n++;
            end
         end
         default: begin
            acts[n] = ACT_NONE;
            seqs[n] = '0;
            n++;
         end
      endcase
      span = window_next - window_base;
      for (i = 0; i < n; i++) begin
         r.action = acts[i];
         r.seq = seqs[i];
         r.in_flight = span[2:0];
         r.all_acked = (span == 16'd0);
         r.last = (i == n - 1);
         response_q.push_back(r);
      end
   endtask

   task automatic compare_field(input string name, input logic [15:0] exp_value,
                                input logic [15:0] act_value);
      if (exp_value !== act_value) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_value, act_value);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         timeout_ticks = TIMEOUT_RESET;
         window_base = '0;
         window_next = '0;
         for (int i = 0; i < WINDOW; i++) begin
            slot_acked[i] = 1'b0;
            slot_elapsed[i] = '0;
         end
         response_q.delete();
         fail_count = 0;
         checked_count = 0;
         pending_results = 0;
      end else begin
         // a response transfer always belongs to an earlier event
         if (rsp_valid && rsp_ready) begin
            if (response_q.size() == 0) begin
               $error("response with no event outstanding: action %0d seq %0d",
                      rsp_action, rsp_seq);
               fail_count++;
            end else begin
               want = response_q.pop_front();
               compare_field("action", 16'(want.action), 16'(rsp_action));
               compare_field("seq", want.seq, rsp_seq);
               compare_field("in_flight", 16'(want.in_flight), 16'(rsp_in_flight));
               compare_field("all_acked", 16'(want.all_acked), 16'(rsp_all_acked));
               compare_field("last", 16'(want.last), 16'(rsp_last));
               checked_count++;
            end
         end
         if (csr_write_en) begin
            timeout_ticks = csr_write_data;
         end
         if (req_valid && req_ready) begin
            apply_event(req_func, req_ack_seq);
         end
         pending_results = response_q.size();
      end
   end

endmodule

@@ tb/selective_repeat_sender_window_test.sv @@
// testbench top for the selective-repeat sender window: clock, reset, event stimulus with
// random idling on both channels, timeout writes, watchdog and verdict
// depends on srsw_pkg, srsw_window_checker and selective_repeat_sender_window
`timescale 1ns / 1ps

module selective_repeat_sender_window_test
   import srsw_pkg::*;
();

   localparam int WINDOW = 4;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 300;
   localparam int SETTLE_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = FUNC_NEW;
   logic [15:0] req_ack_seq = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_action;
   logic [15:0] rsp_seq;
   logic [2:0]  rsp_in_flight;
   logic        rsp_all_acked;
   logic        rsp_last;
   logic        csr_write_en = 1'b0;
   logic [15:0] csr_write_data = '0;

   int          fail_count;
   int          pending_results;
   int          checked_count;
   logic [15:0] window_base;
   logic [15:0] window_next;
   bit          idle_on = 1'b0;
   int          events_sent = 0;
   int          quiet_cycles = 0;
   int          stall_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   selective_repeat_sender_window #(
      .WINDOW   (WINDOW),
      .SEQ_BITS (16)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_ack_seq    (req_ack_seq),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_action     (rsp_action),
      .rsp_seq        (rsp_seq),
      .rsp_in_flight  (rsp_in_flight),
      .rsp_all_acked  (rsp_all_acked),
      .rsp_last       (rsp_last),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   srsw_window_checker #(
      .WINDOW (WINDOW)
   ) window_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_ack_seq     (req_ack_seq),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_action      (rsp_action),
      .rsp_seq         (rsp_seq),
      .rsp_in_flight   (rsp_in_flight),
      .rsp_all_acked   (rsp_all_acked),
      .rsp_last        (rsp_last),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .checked_count   (checked_count),
      .window_base     (window_base),
      .window_next     (window_next)
   );

   // response side stalls at random while idling is on
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 10);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic push_event(input logic [1:0] func, input logic [15:0] ack);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_ack_seq <= ack;
      do @(posedge clock); while (!req_ready);
      events_sent++;
      @(negedge clock);
   endtask

   task automatic random_event();
      int          pick;
      logic [15:0] noise;
      pick = $urandom_range(0, 99);
      noise = 16'($urandom_range(0, 65535));
      if (pick < 30) begin
         push_event(FUNC_NEW, noise);
      end else if (pick < 62) begin
         // mostly inside the window, sometimes one past its end
         push_event(FUNC_ACK, window_base + 16'($urandom_range(0, WINDOW)));
      end else if (pick < 70) begin
         push_event(FUNC_ACK, noise);
      end else if (pick < 95) begin
         push_event(FUNC_TICK, noise);
      end else begin
         push_event(FUNC_UNUSED, noise);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
   endtask

   task automatic write_timeout(input logic [15:0] value);
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [15:0] sweep_list [6];
      int          k;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_on = 1'b1;

      write_timeout(16'd3);
      push_event(FUNC_TICK, 16'hFFFF);       // tick with nothing in flight
      push_event(FUNC_ACK, 16'h0000);        // nothing sent yet
      push_event(FUNC_UNUSED, 16'hA5A5);
      repeat (5) push_event(FUNC_NEW, 16'h0000);   // fifth one finds the window full
      push_event(FUNC_ACK, 16'd2);
      push_event(FUNC_ACK, 16'd2);           // repeated ack
      push_event(FUNC_ACK, 16'hFFFF);        // behind the base
      push_event(FUNC_ACK, 16'd4);           // not sent yet
      push_event(FUNC_ACK, 16'd0);           // base slides to 1
      repeat (4) push_event(FUNC_TICK, 16'h0000);  // slots 1 and 3 expire
      push_event(FUNC_ACK, 16'd1);           // base slides past 1 and 2
      repeat (3) push_event(FUNC_NEW, 16'h0000);
      write_timeout(16'd0);
      repeat (2) push_event(FUNC_TICK, 16'h5A5A);  // every open slot retransmits
      write_timeout(16'd1);
      repeat (2) push_event(FUNC_TICK, 16'h0000);
      for (k = 6; k >= 3; k--) push_event(FUNC_ACK, 16'(k));

      // full window under the largest timeout, then every slot expires in one tick
      write_timeout(16'hFFFF);
      repeat (4) push_event(FUNC_NEW, 16'h0000);
      repeat (3) push_event(FUNC_TICK, 16'h0000);
      write_timeout(16'd2);
      push_event(FUNC_TICK, 16'h0000);
      repeat (4) push_event(FUNC_ACK, window_base);

      sweep_list = '{16'd2, 16'd0, 16'd1, 16'hFFFF, 16'($urandom_range(3, 9)),
                     TIMEOUT_RESET};
      for (k = 0; k < 6; k++) begin
         idle_on = (k != 5);
         write_timeout(sweep_list[k]);
         repeat (28) random_event();
      end

      drain();
      repeat (20) @(negedge clock);
      $display("run: %0d events, %0d responses compared, full window and four retransmits",
               events_sent, checked_count);
      $display("timeouts 0, 1, 2, 3, small random, 2000 and 65535; stray and repeated acks");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ selective_repeat_sender_window.f @@
rtl/core/srsw_pkg.sv
rtl/core/srsw_cell.sv
rtl/core/selective_repeat_sender_window.sv
tb/srsw_window_checker.sv
tb/selective_repeat_sender_window_test.sv
